// File: rtl/salwc_pkg.sv
package salwc_pkg;

  localparam int WAYS_DEF      = 8;
  localparam int SETS_DEF      = 64;
  localparam int ADDR_BITS_DEF = 32;

  localparam logic OP_WRITE       = 1'b1;
  localparam logic KIND_FETCH     = 1'b0;
  localparam logic KIND_WRITEBACK = 1'b1;

  localparam logic REG_WAYS = 1'b0;
  localparam logic REG_SETS = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] target_address;
    logic        last;
  } out_item_t;

endpackage

// File: rtl/salwc_div.sv
module salwc_div #(
  parameter int N  = 32,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [N-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [N-1:0]  quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]  dvd_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_r, dvd_r[N-1]};
    ge      = (sh >= {1'b0, dvs_r});
    diff    = sh - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(N - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[N-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// File: rtl/salwc_ram.sv
module salwc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 296,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/set_assoc_lru_writeback_cache.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid/in_ready     salwc_pkg::in_item_t (opcode, address)
// out_     output     out_valid/out_ready   salwc_pkg::out_item_t (kind, target_address, last)
// cfg_     input      APB write/read        ways_used at 0, sets_used at 4
//
// An access runs the one-bit-a-cycle divider twice for the set index, then does one
// row read and one row write of the set memory. After reset a clearing pass over all
// SETS rows of the set memory runs before the first transaction is taken. A new access
// is taken while earlier results wait in the two-entry output queue; the row write stalls
// until that queue is empty.
module set_assoc_lru_writeback_cache #(
  parameter int WAYS      = salwc_pkg::WAYS_DEF,
  parameter int SETS      = salwc_pkg::SETS_DEF,
  parameter int ADDR_BITS = salwc_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  salwc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output salwc_pkg::out_item_t out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int TW  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int RW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int DWA = $clog2(WAYS + 1);
  localparam int DWS = $clog2(SETS + 1);
  localparam int DW  = (DWA > DWS) ? DWA : DWS;
  localparam int LINE_W = TW + 2 + RW;
  localparam int ROW_W  = WAYS * LINE_W;
  localparam logic [RW-1:0] RANK_MAX = RW'(WAYS - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIVA = 3'd2;
  localparam logic [2:0] ST_DIVB = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_LOOK = 3'd5;

  typedef struct packed {
    logic [TW-1:0] tag;
    logic          valid;
    logic          dirty;
    logic [RW-1:0] rank;
  } line_t;

  logic [3:0]    ways_r;
  logic [6:0]    sets_r;
  logic [DW-1:0] wu_c;
  logic [DW-1:0] su_c;
  logic [2:0]    st_r;
  logic [AW-1:0] clr_cnt_r;
  logic          op_r;
  logic [TW-1:0] addr_r;
  logic [AW-1:0] set_r;

  logic          div_start;
  logic [TW-1:0] div_dvd;
  logic [DW-1:0] div_dvs;
  logic          div_done;
  logic [TW-1:0] div_quot;
  logic [DW-1:0] div_rem;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_addr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  line_t [WAYS-1:0] rd_row;
  line_t [WAYS-1:0] new_row;
  logic [WAYS-1:0]  inuse;
  logic [WAYS-1:0]  ok;
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  freem;
  logic [WAYS-1:0]  vic_oh;
  logic [WAYS-1:0]  hit_oh;
  logic [WAYS-1:0]  free_oh;
  logic [WAYS-1:0]  sel_oh;
  logic             hit;
  logic             full;
  logic [RW-1:0]    thr;
  logic [TW-1:0]    vic_tag;
  logic             vic_dirty;
  logic             wb_need;
  logic             load;

  salwc_pkg::out_item_t q0_r;
  salwc_pkg::out_item_t q1_r;
  logic [1:0]           q_cnt_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= 4'd8;
      sets_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        salwc_pkg::REG_WAYS: ways_r <= cfg_pwdata[3:0];
        salwc_pkg::REG_SETS: sets_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      salwc_pkg::REG_WAYS: cfg_prdata = {28'b0, ways_r};
      salwc_pkg::REG_SETS: cfg_prdata = {25'b0, sets_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (ways_r == 4'd0) begin
      wu_c = DW'(1);
    end else if ({28'b0, ways_r} > 32'(WAYS)) begin
      wu_c = DW'(WAYS);
    end else begin
      wu_c = DW'(ways_r);
    end
    if (sets_r == 7'd0) begin
      su_c = DW'(1);
    end else if ({25'b0, sets_r} > 32'(SETS)) begin
      su_c = DW'(SETS);
    end else begin
      su_c = DW'(sets_r);
    end
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign div_start = (st_r == ST_IDLE && in_valid) || (st_r == ST_DIVA && div_done);
  assign div_dvd   = (st_r == ST_IDLE) ? in_data.address[TW-1:0] : div_quot;
  assign div_dvs   = (st_r == ST_IDLE) ? wu_c : su_c;

  salwc_div #(.N(TW), .DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign load      = (st_r == ST_LOOK) && (q_cnt_r == 2'd0);
  assign ram_we    = (st_r == ST_CLR) || load;
  assign ram_re    = (st_r == ST_RD);
  assign ram_addr  = (st_r == ST_CLR) ? clr_cnt_r : set_r;
  assign ram_wdata = (st_r == ST_CLR) ? '0 : new_row;

  salwc_ram #(.DEPTH(SETS), .WIDTH(ROW_W), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_row = ram_rdata;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      inuse[w] = (w < int'(wu_c));
      ok[w]    = inuse[w] && rd_row[w].valid;
      match[w] = ok[w] && (rd_row[w].tag == addr_r);
      freem[w] = inuse[w] && !rd_row[w].valid;
    end
    for (int w = 0; w < WAYS; w++) begin
      vic_oh[w] = ok[w];
      for (int j = 0; j < WAYS; j++) begin
        if (j != w && ok[j]) begin
          if (j < w) begin
            if (!(rd_row[j].rank < rd_row[w].rank)) vic_oh[w] = 1'b0;
          end else begin
            if (rd_row[j].rank > rd_row[w].rank) vic_oh[w] = 1'b0;
          end
        end
      end
    end
  end

  assign hit_oh  = match & (~match + WAYS'(1));
  assign free_oh = freem & (~freem + WAYS'(1));
  assign hit     = |match;
  assign full    = &(ok | ~inuse);
  assign sel_oh  = hit ? hit_oh : (full ? vic_oh : free_oh);

  always_comb begin
    thr       = '0;
    vic_tag   = '0;
    vic_dirty = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (sel_oh[w]) thr = thr | rd_row[w].rank;
      if (vic_oh[w]) begin
        vic_tag   = vic_tag | rd_row[w].tag;
        vic_dirty = vic_dirty | rd_row[w].dirty;
      end
    end
  end

  assign wb_need = !hit && full && vic_dirty;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_row[w] = rd_row[w];
      if (sel_oh[w]) begin
        new_row[w].rank = '0;
        if (hit) begin
          new_row[w].dirty = rd_row[w].dirty || (op_r == salwc_pkg::OP_WRITE);
        end else begin
          new_row[w].tag   = addr_r;
          new_row[w].valid = 1'b1;
          new_row[w].dirty = (op_r == salwc_pkg::OP_WRITE);
        end
      end else if (ok[w] && (!(hit || full) || rd_row[w].rank < thr)) begin
        if (rd_row[w].rank < RANK_MAX) new_row[w].rank = rd_row[w].rank + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      case (st_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(SETS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) st_r <= ST_DIVA;
        end
        ST_DIVA: begin
          if (div_done) st_r <= ST_DIVB;
        end
        ST_DIVB: begin
          if (div_done) st_r <= ST_RD;
        end
        ST_RD: st_r <= ST_LOOK;
        ST_LOOK: begin
          if (q_cnt_r == 2'd0) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_valid) begin
      op_r   <= in_data.opcode;
      addr_r <= in_data.address[TW-1:0];
    end
    if (st_r == ST_DIVB && div_done) begin
      set_r <= div_rem[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else if (load && !hit) begin
      q_cnt_r <= wb_need ? 2'd2 : 2'd1;
    end else if (out_valid && out_ready) begin
      q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0_r.kind           <= salwc_pkg::KIND_FETCH;
      q0_r.target_address <= 32'(addr_r);
      q0_r.last           <= !wb_need;
      q1_r.kind           <= salwc_pkg::KIND_WRITEBACK;
      q1_r.target_address <= 32'(vic_tag);
      q1_r.last           <= 1'b1;
    end else if (out_valid && out_ready) begin
      q0_r <= q1_r;
    end
  end

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q0_r;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r != 2'd3)
    else $error("output queue count out of range");
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !hit) |=> (q_cnt_r != 2'd0))
    else $error("miss produced no result");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLR) |-> (q_cnt_r == 2'd0 && !in_ready))
    else $error("activity during clearing pass");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIVA || st_r == ST_DIVB))
    else $error("divider finished outside a divide state");

endmodule

// File: tb/sv/tb.sv
module tb;

  localparam int NWAYS = salwc_pkg::WAYS_DEF;
  localparam int NSETS = salwc_pkg::SETS_DEF;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  salwc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  salwc_pkg::out_item_t out_data;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [2:0]           cfg_paddr = '0;
  logic [31:0]          cfg_pwdata = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  set_assoc_lru_writeback_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic [3:0]  ways_reg = 4'd8;
  logic [6:0]  sets_reg = 7'd64;
  logic [31:0] tag_mem [NWAYS*NSETS];
  bit          valid_mem [NWAYS*NSETS];
  bit          dirty_mem [NWAYS*NSETS];
  int          rank_mem [NWAYS*NSETS];

  salwc_pkg::in_item_t  access_queue [$];
  salwc_pkg::out_item_t pending_mem_requests [$];
  int          error_count = 0;
  bit          idle_on = 1'b1;
  int          send_gap = 0;
  int          recv_stall = 0;
  logic [31:0] hot_addrs [24];

  function automatic void cache_access(salwc_pkg::in_item_t acc);
    int wu, su, set_base, hit, free_way, victim, victim_rank, nvalid, slot, hr;
    salwc_pkg::out_item_t req;
    wu = (ways_reg < 1) ? 1 : (ways_reg > NWAYS) ? NWAYS : int'(ways_reg);
    su = (sets_reg < 1) ? 1 : (sets_reg > NSETS) ? NSETS : int'(sets_reg);
    set_base = int'((acc.address / wu) % su) * NWAYS;
    hit = -1;
    free_way = -1;
    victim = -1;
    victim_rank = 0;
    nvalid = 0;
    for (int w = 0; w < wu; w++) begin
      if (valid_mem[set_base+w]) begin
        nvalid++;
        if (hit < 0 && tag_mem[set_base+w] == acc.address) hit = w;
        if (victim < 0 || rank_mem[set_base+w] > victim_rank) begin
          victim = w;
          victim_rank = rank_mem[set_base+w];
        end
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (hit >= 0) begin
      hr = rank_mem[set_base+hit];
      for (int w = 0; w < wu; w++)
        if (valid_mem[set_base+w] && w != hit && rank_mem[set_base+w] < hr &&
            rank_mem[set_base+w] < NWAYS-1)
          rank_mem[set_base+w]++;
      rank_mem[set_base+hit] = 0;
      if (acc.opcode == salwc_pkg::OP_WRITE) dirty_mem[set_base+hit] = 1'b1;
      return;
    end
    req.kind = salwc_pkg::KIND_FETCH;
    req.target_address = acc.address;
    req.last = 1'b1;
    if (nvalid >= wu && victim >= 0) begin
      slot = set_base + victim;
      if (dirty_mem[slot]) begin
        req.last = 1'b0;
        pending_mem_requests.push_back(req);
        req.kind = salwc_pkg::KIND_WRITEBACK;
        req.target_address = tag_mem[slot];
        req.last = 1'b1;
      end
      pending_mem_requests.push_back(req);
      for (int w = 0; w < wu; w++)
        if (valid_mem[set_base+w] && w != victim && rank_mem[set_base+w] < victim_rank &&
            rank_mem[set_base+w] < NWAYS-1)
          rank_mem[set_base+w]++;
    end else begin
      pending_mem_requests.push_back(req);
      if (free_way < 0) return;
      slot = set_base + free_way;
      for (int w = 0; w < wu; w++)
        if (valid_mem[set_base+w] && rank_mem[set_base+w] < NWAYS-1)
          rank_mem[set_base+w]++;
    end
    tag_mem[slot] = acc.address;
    valid_mem[slot] = 1'b1;
    dirty_mem[slot] = (acc.opcode == salwc_pkg::OP_WRITE);
    rank_mem[slot] = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) cache_access(in_data);
      if (access_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else begin
        in_data <= access_queue.pop_front();
        in_valid <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, 13) : 0;
      end
    end
  end

  always @(posedge clk) begin
    salwc_pkg::out_item_t want;
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (pending_mem_requests.size() == 0) begin
        $display("%0t: unexpected request, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_mem_requests.pop_front();
        if (out_data.kind !== want.kind) begin
          $display("%0t: kind mismatch, expected %0b, actual %0b",
                   $time, want.kind, out_data.kind);
          error_count++;
        end
        if (out_data.target_address !== want.target_address) begin
          $display("%0t: target_address mismatch, expected %h, actual %h",
                   $time, want.target_address, out_data.target_address);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_data.last);
          error_count++;
        end
      end
      draw = idle_on ? $urandom_range(0, 13) : 0;
      recv_stall <= draw;
      if (draw > 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (recv_stall > 1) recv_stall <= recv_stall - 1;
      else out_ready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == 3'(4 * salwc_pkg::REG_WAYS)) ways_reg = value[3:0];
    else sets_reg = value[6:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic push_access(input logic op, input logic [31:0] addr);
    salwc_pkg::in_item_t acc;
    acc.opcode = op;
    acc.address = addr;
    access_queue.push_back(acc);
  endtask

  task automatic drain();
    while (access_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_mem_requests.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_phase(input int wv, input int sv, input int count);
    int wu, su;
    wu = (wv < 1) ? 1 : (wv > NWAYS) ? NWAYS : wv;
    su = (sv < 1) ? 1 : (sv > NSETS) ? NSETS : sv;
    reg_write(3'(4 * salwc_pkg::REG_WAYS), 32'(wv));
    reg_write(3'(4 * salwc_pkg::REG_SETS), 32'(sv));
    for (int i = 0; i < 24; i++)
      hot_addrs[i] = 32'($urandom_range(0, 7) * wu * su + $urandom_range(0, 2) % su * wu
                         + $urandom_range(0, wu - 1));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        push_access(1'($urandom_range(0, 1)), hot_addrs[$urandom_range(0, 23)]);
      else
        push_access(1'($urandom_range(0, 1)), $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    reg_write(3'(4 * salwc_pkg::REG_WAYS), 32'd8);
    reg_write(3'(4 * salwc_pkg::REG_SETS), 32'd64);
    push_access(1'b1, 32'h0000_0000);
    push_access(1'b0, 32'h0000_0000);
    push_access(1'b0, 32'hFFFF_FFFF);
    push_access(1'b1, 32'hFFFF_FFFF);
    for (int k = 1; k <= 8; k++) push_access(1'b1, 32'(k * 512));
    push_access(1'b0, 32'd2560);
    push_access(1'b0, 32'd4608);
    push_access(1'b0, 32'd5120);
    push_access(1'b1, 32'hAAAA_AAAA);
    push_access(1'b0, 32'h5555_5555);
    drain();

    random_phase(8, 64, 90);
    random_phase(1, 1, 90);
    idle_on = 1'b0;
    random_phase(15, 127, 90);
    idle_on = 1'b1;
    random_phase(0, 0, 90);
    random_phase(3, 5, 90);
    random_phase(8, 64, 90);

    if (error_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
